FILE: rtl/dae_pkg.sv
// Shared constants for the distributed arithmetic encoder.
`timescale 1ns / 1ps

package dae_pkg;

    localparam int PRECISION_DEF = 16;
    localparam int MAX_RESULTS   = 17;
    localparam int HALF_REMAIN   = 15;
    localparam int CFG_IDX_W     = 2;

    localparam logic [15:0] PEND_MAX      = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [15:0] PROB_ONE_RST  = 16'd46341;
    localparam logic [15:0] PROB_ZERO_RST = 16'd46341;
    localparam logic [15:0] TOTAL_RST     = 16'd200;

    localparam logic [CFG_IDX_W-1:0] CFG_PROB_ONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_ZERO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 2'd2;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic        lead;
        logic [15:0] follow;
        logic        ovf;
    } t_result;

endpackage

FILE: rtl/distributed_arith_encoder.sv
// Binary arithmetic encoder with overlapping intervals, iterative renormalisation.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_opcode, i_symbol_bit
//  out     | source    | o_out_valid / i_out_ready  | o_lead_bit, o_follow_count, o_last,
//          |           |                            | o_pending_overflow
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Encode: accept, a multiply step, a split step, then renorm steps (up to PRECISION+1),
// one renorm step per cycle while a held result is not stalled by a full output register,
// then a step to see the loop end, and a flush of the held result.
// Finish: accept, then the two output states S_FIN1 and S_FIN2.
// Reset is synchronous; no clearing pass. A full output register stalls the sequencer
// only when a result has to move on.
`timescale 1ns / 1ps

module distributed_arith_encoder #(
    parameter int PRECISION = dae_pkg::PRECISION_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic                          i_symbol_bit,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_lead_bit,
    output logic [15:0]                   o_follow_count,
    output logic                          o_last,
    output logic                          o_pending_overflow,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dae_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import dae_pkg::*;

    localparam int RW = PRECISION + 1;
    localparam int PW = RW + 17;
    localparam int WW = PRECISION + 2;
    localparam int IW = $clog2(PRECISION + 2);
    localparam int NW = $clog2(MAX_RESULTS + 1);
    localparam logic [PRECISION-1:0] SECOND = PRECISION'(1) << (PRECISION - 2);
    localparam logic [PW-1:0] ROUND_HALF = PW'(32768);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SPLIT, S_RENORM, S_DRAIN, S_FIN1, S_FIN2
    } t_state;

    t_state               r_state;
    logic [15:0]          r_prob_one, r_prob_zero, r_total;
    logic [PRECISION-1:0] r_low, r_high;
    logic [15:0]          r_pending, r_count;
    logic                 r_sat;
    logic                 r_sym, r_half;
    logic [RW-1:0]        r_range;
    logic [PW-1:0]        r_prod;
    logic [IW-1:0]        r_iter;
    logic [NW-1:0]        r_n;
    t_result              r_hold;
    logic                 r_hold_valid;
    t_result              r_out;
    logic                 r_out_valid, r_out_last;

    logic                 w_out_free;
    logic                 w_renorm_stop, w_out_load;
    logic [15:0]          w_remaining;
    logic [RW-1:0]        w_range;
    logic [16:0]          w_factor;
    logic [PW-1:0]        w_prod, w_round;
    logic [RW:0]          w_range_p1;
    logic [RW-1:0]        w_range_m1;
    logic [WW-1:0]        w_raw, w_clamp;
    logic [PRECISION-1:0] w_width;
    logic                 w_lt, w_ht, w_straddle, w_fin_h, w_fin_bit;
    logic [PRECISION-1:0] w_low_adj, w_high_adj;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_remaining = (r_count < r_total) ? (r_total - r_count) : 16'd0;
    assign w_range     = (r_high >= r_low) ? (RW'(r_high) - RW'(r_low) + RW'(1)) : RW'(1);
    assign w_factor    = r_sym ? (17'h10000 - {1'b0, r_prob_one}) : {1'b0, r_prob_zero};
    assign w_prod      = PW'(w_range) * PW'(w_factor);
    assign w_round     = r_prod + ROUND_HALF;
    assign w_range_p1  = {1'b0, r_range} + (RW + 1)'(1);
    assign w_range_m1  = r_range - RW'(1);

    always_comb begin
        w_raw = r_half ? {1'b0, w_range_p1[RW:1]} : w_round[PW-1:16];
        w_clamp = w_raw;
        if (w_clamp > {1'b0, w_range_m1}) begin
            w_clamp = {1'b0, w_range_m1};
        end
        if (w_clamp == '0) begin
            w_clamp = WW'(1);
        end
        w_width = w_clamp[PRECISION-1:0];
    end

    assign w_lt       = r_low[PRECISION-1];
    assign w_ht       = r_high[PRECISION-1];
    assign w_straddle = (w_lt != w_ht) && r_low[PRECISION-2] && !r_high[PRECISION-2];
    assign w_low_adj  = w_straddle ? (r_low - SECOND) : r_low;
    assign w_high_adj = w_straddle ? (r_high - SECOND) : r_high;
    assign w_fin_h    = r_high[PRECISION-2];
    assign w_fin_bit  = w_fin_h ? r_high[PRECISION-1] : r_low[PRECISION-1];

    assign w_renorm_stop = (r_iter > IW'(PRECISION)) || (r_n == NW'(MAX_RESULTS));

    // output register loads a transaction this cycle
    always_comb begin
        unique case (r_state)
            S_RENORM: w_out_load = !w_renorm_stop && (w_lt == w_ht) && r_hold_valid
                                   && w_out_free;
            S_DRAIN:  w_out_load = r_hold_valid && w_out_free;
            S_FIN1, S_FIN2: w_out_load = w_out_free;
            default:  w_out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prob_one   <= PROB_ONE_RST;
            r_prob_zero  <= PROB_ZERO_RST;
            r_total      <= TOTAL_RST;
            r_low        <= '0;
            r_high       <= '1;
            r_pending    <= '0;
            r_count      <= '0;
            r_sat        <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_iter       <= '0;
            r_n          <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PROB_ONE:  r_prob_one  <= i_cfg_data;
                    CFG_PROB_ZERO: r_prob_zero <= i_cfg_data;
                    CFG_TOTAL:     r_total     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_opcode == OP_FINISH) begin
                            r_state <= S_FIN1;
                        end else begin
                            r_sym   <= i_symbol_bit;
                            r_half  <= (w_remaining <= 16'(HALF_REMAIN));
                            if (r_count < COUNT_MAX) begin
                                r_count <= r_count + 16'd1;
                            end
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_range <= w_range;
                    r_prod  <= w_prod;
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    if (r_range >= RW'(2)) begin
                        if (r_sym) begin
                            r_low <= r_low + w_width;
                        end else begin
                            r_high <= r_low + w_width - PRECISION'(1);
                        end
                    end
                    r_iter  <= '0;
                    r_n     <= '0;
                    r_state <= S_RENORM;
                end
                S_RENORM: begin
                    priority if (w_renorm_stop) begin
                        r_state <= S_DRAIN;
                    end else if (w_lt == w_ht) begin
                        if (!r_hold_valid || w_out_free) begin
                            if (r_hold_valid) begin
                                r_out       <= r_hold;
                                r_out_last  <= 1'b0;
                            end
                            r_hold       <= '{lead: w_ht, follow: r_pending, ovf: r_sat};
                            r_hold_valid <= 1'b1;
                            r_pending    <= '0;
                            r_sat        <= 1'b0;
                            r_low        <= {r_low[PRECISION-2:0], 1'b0};
                            r_high       <= {r_high[PRECISION-2:0], 1'b1};
                            r_iter       <= r_iter + IW'(1);
                            r_n          <= r_n + NW'(1);
                        end
                    end else if (w_straddle) begin
                        if (r_pending < PEND_MAX) begin
                            r_pending <= r_pending + 16'd1;
                        end else begin
                            r_sat <= 1'b1;
                        end
                        r_low  <= {w_low_adj[PRECISION-2:0], 1'b0};
                        r_high <= {w_high_adj[PRECISION-2:0], 1'b1};
                        r_iter <= r_iter + IW'(1);
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_hold_valid) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out        <= r_hold;
                        r_out_last   <= 1'b1;
                        r_hold_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                S_FIN1: begin
                    if (w_out_free) begin
                        r_out       <= '{lead: w_fin_bit, follow: r_pending, ovf: r_sat};
                        r_out_last  <= 1'b0;
                        r_pending   <= '0;
                        r_sat       <= 1'b0;
                        r_state     <= S_FIN2;
                    end
                end
                S_FIN2: begin
                    if (w_out_free) begin
                        r_out       <= '{lead: !w_fin_h, follow: 16'd0, ovf: 1'b0};
                        r_out_last  <= 1'b1;
                        r_low       <= '0;
                        r_high      <= '1;
                        r_pending   <= '0;
                        r_count     <= '0;
                        r_sat       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_out_valid;
    assign o_lead_bit         = r_out.lead;
    assign o_follow_count     = r_out.follow;
    assign o_pending_overflow = r_out.ovf;
    assign o_last             = r_out_last;

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("held result left over in idle");
    a_result_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(MAX_RESULTS))
        else $error("result count above limit");
    a_interval_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_high)
        else $error("interval low above high");
    a_sat_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_pending == PEND_MAX))
        else $error("saturation flag without full pending count");
    a_split_follows_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_SPLIT))
        else $error("multiply step not followed by split");
`endif

endmodule
